// ----- rtl/core/tkst_pkg.sv -----
// ---------------------------------------------------------------------------
// tkst_pkg
// Shared widths, controller states and controller/datapath interface types
// for the top-k score table.
// ---------------------------------------------------------------------------
package tkst_pkg;

    localparam int TAG_W   = 64;
    localparam int SCORE_W = 24;
    localparam int RANK_W  = 4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              update;
        logic              load_out;
        logic              out_last;
        logic [RANK_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              out_free;
        logic [RANK_W-1:0] last_rank;
    } t_status;

endpackage

// ----- rtl/core/top_k_score_table.sv -----
// ---------------------------------------------------------------------------
// top_k_score_table
// Keeps the TABLE_SIZE best (tag, score) entries sorted by descending score
// and dumps every occupied rank after every offer.
// ---------------------------------------------------------------------------
// The table is updated in the cycle an offer is taken, by a compare of the
// new score against every stored score and a one-slot shift of the entries
// below the insertion point; then the sequencer emits one ranked entry per
// cycle from the table registers while the output is free, one beat for each
// of the N ranks occupied after the offer (1 to TABLE_SIZE); back-pressure
// stalls the walk. The next offer is taken right after the beat marked last
// is loaded, while that beat may still wait in the output register.
module top_k_score_table #(
    parameter int TABLE_SIZE = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tkst_pkg::TAG_W-1:0]   i_player_tag,
    input  logic [tkst_pkg::SCORE_W-1:0] i_new_score,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tkst_pkg::RANK_W-1:0]  o_rank,
    output logic [tkst_pkg::TAG_W-1:0]   o_entry_tag,
    output logic [tkst_pkg::SCORE_W-1:0] o_entry_score,
    output logic                         o_accepted,
    output logic                         o_last
);

    tkst_pkg::t_cmd    cmd;
    tkst_pkg::t_status status;

    tkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tkst_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_player_tag  (i_player_tag),
        .i_new_score   (i_new_score),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_rank        (o_rank),
        .o_entry_tag   (o_entry_tag),
        .o_entry_score (o_entry_score),
        .o_accepted    (o_accepted),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/core/tkst_dpath.sv -----
// ---------------------------------------------------------------------------
// tkst_dpath
// Sorted entry table with combinational ordered insertion and the output
// beat register.
// ---------------------------------------------------------------------------
module tkst_dpath #(
    parameter int TABLE_SIZE = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tkst_pkg::t_cmd               i_cmd,
    output tkst_pkg::t_status            o_status,
    input  logic [tkst_pkg::TAG_W-1:0]   i_player_tag,
    input  logic [tkst_pkg::SCORE_W-1:0] i_new_score,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [tkst_pkg::RANK_W-1:0]  o_rank,
    output logic [tkst_pkg::TAG_W-1:0]   o_entry_tag,
    output logic [tkst_pkg::SCORE_W-1:0] o_entry_score,
    output logic                         o_accepted,
    output logic                         o_last
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);

    logic [tkst_pkg::TAG_W-1:0]   r_tag   [TABLE_SIZE];
    logic [tkst_pkg::SCORE_W-1:0] r_score [TABLE_SIZE];
    logic [tkst_pkg::TAG_W-1:0]   n_tag   [TABLE_SIZE];
    logic [tkst_pkg::SCORE_W-1:0] n_score [TABLE_SIZE];
    logic [CNT_W-1:0]             r_count;
    logic                         r_accepted;

    logic                         r_out_valid;
    logic [tkst_pkg::RANK_W-1:0]  r_out_rank;
    logic [tkst_pkg::TAG_W-1:0]   r_out_tag;
    logic [tkst_pkg::SCORE_W-1:0] r_out_score;
    logic                         r_out_accepted;
    logic                         r_out_last;

    logic [TABLE_SIZE-1:0]        occ;
    logic [TABLE_SIZE-1:0]        ge;
    logic [TABLE_SIZE-1:0]        le_min;
    logic [tkst_pkg::SCORE_W-1:0] min_score;
    logic                         full;
    logic                         do_write;

    assign full      = (r_count == CNT_W'(TABLE_SIZE));
    assign min_score = r_score[TABLE_SIZE-1];
    assign do_write  = !full || (i_new_score > min_score);

    genvar j;
    generate
        for (j = 0; j < TABLE_SIZE; j++) begin : g_slot
            assign occ[j]    = (CNT_W'(j) < r_count);
            assign ge[j]     = occ[j] && (r_score[j] >= i_new_score);
            assign le_min[j] = (r_score[j] <= min_score);

            if (j == 0) begin : g_head
                always_comb begin
                    if (!ge[0]) begin
                        n_tag[0]   = i_player_tag;
                        n_score[0] = i_new_score;
                    end else begin
                        n_tag[0]   = r_tag[0];
                        n_score[0] = r_score[0];
                    end
                end
            end else begin : g_body
                logic beyond;
                assign beyond = full ? le_min[j-1] : !occ[j-1];
                always_comb begin
                    priority if (ge[j]) begin
                        n_tag[j]   = r_tag[j];
                        n_score[j] = r_score[j];
                    end else if (ge[j-1]) begin
                        n_tag[j]   = i_player_tag;
                        n_score[j] = i_new_score;
                    end else if (!beyond) begin
                        n_tag[j]   = r_tag[j-1];
                        n_score[j] = r_score[j-1];
                    end else begin
                        n_tag[j]   = r_tag[j];
                        n_score[j] = r_score[j];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && do_write) begin
            for (int k = 0; k < TABLE_SIZE; k++) begin
                r_tag[k]   <= n_tag[k];
                r_score[k] <= n_score[k];
            end
        end
        if (i_cmd.update) begin
            r_accepted <= do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rank     <= i_cmd.idx;
            r_out_tag      <= r_tag[i_cmd.idx[IDX_W-1:0]];
            r_out_score    <= r_score[i_cmd.idx[IDX_W-1:0]];
            r_out_accepted <= r_accepted;
            r_out_last     <= i_cmd.out_last;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.last_rank = tkst_pkg::RANK_W'(r_count) - tkst_pkg::RANK_W'(1);

    assign o_out_valid   = r_out_valid;
    assign o_rank        = r_out_rank;
    assign o_entry_tag   = r_out_tag;
    assign o_entry_score = r_out_score;
    assign o_accepted    = r_out_accepted;
    assign o_last        = r_out_last;

endmodule

// ----- rtl/core/tkst_ctrl.sv -----
// ---------------------------------------------------------------------------
// tkst_ctrl
// Sequencer: takes one offer, triggers the table update, then walks the
// occupied ranks one output beat at a time.
// ---------------------------------------------------------------------------
module tkst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tkst_pkg::t_status i_status,
    output tkst_pkg::t_cmd    o_cmd
);

    tkst_pkg::t_state              r_state;
    tkst_pkg::t_state              n_state;
    logic [tkst_pkg::RANK_W-1:0]   r_idx;
    logic [tkst_pkg::RANK_W-1:0]   n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkst_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_in_ready     = 1'b0;
        o_cmd.update   = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.out_last = (r_idx == i_status.last_rank);
        o_cmd.idx      = r_idx;
        unique case (r_state)
            tkst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.update = 1'b1;
                    n_idx        = '0;
                    n_state      = tkst_pkg::ST_EMIT;
                end
            end
            tkst_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (o_cmd.out_last) begin
                        n_state = tkst_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + tkst_pkg::RANK_W'(1);
                    end
                end
            end
            default: begin
                n_state = tkst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/tkst_checker.sv -----
// ---------------------------------------------------------------------------
// tkst_checker
// Port-level checks for the top-k score table, bound to the top level.
// ---------------------------------------------------------------------------
module tkst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [tkst_pkg::RANK_W-1:0]  o_rank,
    input logic [tkst_pkg::TAG_W-1:0]   o_entry_tag,
    input logic [tkst_pkg::SCORE_W-1:0] o_entry_score,
    input logic                         o_accepted,
    input logic                         o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("offer taken while previous dump pending");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rank)
            && $stable(o_entry_tag) && $stable(o_entry_score) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_dump_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid
            && (o_rank == tkst_pkg::RANK_W'($past(o_rank) + tkst_pkg::RANK_W'(1)))
            && (o_entry_score <= $past(o_entry_score))
            && (o_accepted == $past(o_accepted)))
        else $error("dump beats out of rank order");

endmodule

bind top_k_score_table tkst_checker u_tkst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_rank        (o_rank),
    .o_entry_tag   (o_entry_tag),
    .o_entry_score (o_entry_score),
    .o_accepted    (o_accepted),
    .o_last        (o_last)
);
